// ----- sv/sacl_pkg.sv -----
package sacl_pkg;

  localparam int ADDR_W    = 64;
  localparam int WAY_OUT_W = 2;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;  // latch the item, read its set
    logic commit;   // write the set back, load the result register
  } ctl_cmd_t;

endpackage

// ----- sv/sacl_in_if.sv -----
interface sacl_in_if;
  import sacl_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ADDR_W-1:0] addr;

  modport source (output valid, cmd, addr, input ready);
  modport sink   (input valid, cmd, addr, output ready);
endinterface

// ----- sv/sacl_out_if.sv -----
interface sacl_out_if;
  import sacl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [WAY_OUT_W-1:0] way;

  modport source (output valid, hit, way, input ready);
  modport sink   (input valid, hit, way, output ready);
endinterface

// ----- sv/sacl_ctl.sv -----
module sacl_ctl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output sacl_pkg::ctl_cmd_t  cmd
);
  import sacl_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready    = (state_r == ST_IDLE);
  assign cmd.capture = in_valid && in_ready;
  // result slot must be free (or draining) before the set is written back
  assign cmd.commit  = (state_r == ST_LOOK) && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.capture) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        if (cmd.commit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_capture_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == ST_LOOK))
    else $error("capture did not enter lookup");
  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (out_valid_r && state_r == ST_IDLE))
    else $error("commit did not present a result");
  a_stall_holds_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK && out_valid_r && !out_ready) |=> (state_r == ST_LOOK))
    else $error("pending item dropped during output stall");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.capture && cmd.commit))
    else $error("capture and commit in the same cycle");
`endif

endmodule

// ----- sv/sacl_dp.sv -----
module sacl_dp #(
  parameter int SET_W       = 6,
  parameter int WAYS        = 4,
  parameter int OFFSET_BITS = 5
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sacl_pkg::ctl_cmd_t                 cmd,
  input  logic                               in_cmd,
  input  logic [sacl_pkg::ADDR_W-1:0]        in_addr,
  output logic                               out_hit,
  output logic [sacl_pkg::WAY_OUT_W-1:0]     out_way
);
  import sacl_pkg::*;

  localparam int NSETS = 1 << SET_W;
  localparam int TAG_W = ADDR_W - SET_W - OFFSET_BITS;
  localparam int IDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  // set memory: tags, valid flags and recency ranks, one row per set
  logic [WAYS-1:0][TAG_W-1:0] tag_mem  [NSETS];
  logic [WAYS-1:0]            vld_mem  [NSETS];
  logic [WAYS-1:0][IDX_W-1:0] rank_mem [NSETS];

  // set written since reset; an untouched set reads as the reset row
  logic [NSETS-1:0] touched_r;

  logic                       cmd_r;
  logic [SET_W-1:0]           set_r;
  logic [TAG_W-1:0]           tag_r;
  logic [WAYS-1:0][TAG_W-1:0] tag_rd_r;
  logic [WAYS-1:0]            vld_rd_r;
  logic [WAYS-1:0][IDX_W-1:0] rank_rd_r;

  logic                       hit_r;
  logic [WAY_OUT_W-1:0]       way_r;

  logic [SET_W-1:0]           in_set;
  logic [WAYS-1:0]            vld_cur;
  logic [WAYS-1:0][IDX_W-1:0] rank_cur;
  logic                       hit_any;
  logic [IDX_W-1:0]           hit_idx;
  logic                       inv_any;
  logic [IDX_W-1:0]           inv_idx;
  logic [IDX_W-1:0]           lru_idx;
  logic [IDX_W-1:0]           victim;
  logic [IDX_W-1:0]           sel;
  logic                       touch;
  logic [IDX_W-1:0]           old_rank;
  logic [WAYS-1:0][TAG_W-1:0] tag_nxt;
  logic [WAYS-1:0]            vld_nxt;
  logic [WAYS-1:0][IDX_W-1:0] rank_nxt;
  logic [IDX_W+1:0]           way_ext;

  assign in_set = in_addr[OFFSET_BITS +: SET_W];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r     <= in_cmd;
      set_r     <= in_set;
      tag_r     <= in_addr[ADDR_W-1 -: TAG_W];
      tag_rd_r  <= tag_mem[in_set];
      vld_rd_r  <= vld_mem[in_set];
      rank_rd_r <= rank_mem[in_set];
    end
    if (cmd.commit) begin
      tag_mem[set_r]  <= tag_nxt;
      vld_mem[set_r]  <= vld_nxt;
      rank_mem[set_r] <= rank_nxt;
      hit_r           <= ~cmd_r & hit_any;
      way_r           <= way_ext[WAY_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touched_r <= '0;
    end else if (cmd.commit) begin
      touched_r[set_r] <= 1'b1;
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      vld_cur[w]  = touched_r[set_r] & vld_rd_r[w];
      rank_cur[w] = touched_r[set_r] ? rank_rd_r[w] : IDX_W'(w);
    end
  end

  // lookup match and fill victim; descending scans so the lowest way wins
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    inv_any = 1'b0;
    inv_idx = '0;
    lru_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vld_cur[w] && tag_rd_r[w] == tag_r) begin
        hit_any = 1'b1;
        hit_idx = IDX_W'(w);
      end
      if (!vld_cur[w]) begin
        inv_any = 1'b1;
        inv_idx = IDX_W'(w);
      end
      if (rank_cur[w] == '0) lru_idx = IDX_W'(w);
    end
  end

  assign victim   = inv_any ? inv_idx : lru_idx;
  assign sel      = cmd_r ? victim : hit_idx;
  assign touch    = cmd_r | hit_any;
  assign old_rank = rank_cur[sel];

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tag_nxt[w]  = tag_rd_r[w];
      vld_nxt[w]  = vld_cur[w];
      rank_nxt[w] = rank_cur[w];
      if (touch) begin
        if (IDX_W'(w) == sel) begin
          rank_nxt[w] = IDX_W'(WAYS - 1);
        end else if (rank_cur[w] > old_rank) begin
          rank_nxt[w] = rank_cur[w] - 1'b1;
        end
      end
      if (cmd_r && IDX_W'(w) == sel) begin
        tag_nxt[w] = tag_r;
        vld_nxt[w] = 1'b1;
      end
    end
  end

  assign way_ext = touch ? {2'b00, sel} : '0;

  assign out_hit = hit_r;
  assign out_way = way_r;

endmodule

// ----- sv/set_assoc_cache_tag_lru_unit.sv -----
// Channel   Dir  Payload               Handshake
// in_chan   in   cmd[0], addr[63:0]    valid/ready, item taken when both high
// out_chan  out  hit[0], way[1:0]      valid/ready, item taken when both high
//
// For each item, the accept edge reads the set row from the set memory into
// registers; the commit edge, once the result slot is free, compares tags,
// updates valid and LRU ranks, writes the row back and loads the result
// register. The set memory is read, then written, once per item.
// Reset (rst_n, synchronous) clears control and the per-set touched flags;
// no clearing pass. A new item is taken while a result waits; a stalled
// result holds the second item's write-back until the slot frees.
module set_assoc_cache_tag_lru_unit #(
  parameter int SET_W       = 6,
  parameter int WAYS        = 4,
  parameter int OFFSET_BITS = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  sacl_in_if.sink           in_chan,
  sacl_out_if.source        out_chan
);
  import sacl_pkg::*;

  ctl_cmd_t cmd;

  // handshake and sequencing
  sacl_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  // set memory, tag match, victim choice and true-LRU rank update
  sacl_dp #(
    .SET_W       (SET_W),
    .WAYS        (WAYS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_cmd  (in_chan.cmd),
    .in_addr (in_chan.addr),
    .out_hit (out_chan.hit),
    .out_way (out_chan.way)
  );

endmodule
